[design/rwsd_pkg.sv]
// Shared types and constants of the readout word stream deframer.
package rwsd_pkg;

    localparam int HISTORY_DEPTH = 9;
    localparam int HEAD_WORDS    = 8;
    localparam int HIST_STORE    = HISTORY_DEPTH - 1;
    localparam int HEAD_BUF      = HEAD_WORDS - 1;
    localparam int CARD_TAP      = 5;

    localparam logic [23:0] HEADER_TAG   = 24'h41505a;
    localparam logic [31:0] TRAILER_WORD = 32'hfafafafa;
    localparam logic [7:0]  CARD_RESET   = 8'd99;
    localparam logic [7:0]  CARD_FIRST   = 8'd1;
    localparam logic [7:0]  CARD_MAX_OK  = 8'd3;

    localparam int          HEAD_CNT_W    = 3;
    localparam logic [2:0]  HEAD_LAST_IDX = 3'd7;

    localparam int          CFG_ADDR_W    = 3;
    localparam logic [2:0]  ADDR_NUM_FECS = 3'h0;
    localparam logic [7:0]  NUM_FECS_RST  = 8'd1;

    typedef enum logic [1:0] {
        KIND_HEAD      = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_TRAILER   = 2'd2,
        KIND_START_ERR = 2'd3
    } t_word_kind;

    typedef enum logic {
        S_WORD,
        S_HEAD
    } t_ctl_state;

    typedef struct packed {
        logic                  accept;
        logic                  head_emit;
        logic [HEAD_CNT_W-1:0] head_idx;
        logic                  head_last;
    } t_ctl_cmd;

    typedef struct packed {
        logic hdr_full_hit;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [31:0] out_word;
        logic [11:0] word_index;
        t_word_kind  word_kind;
        logic [7:0]  card_id;
        logic [31:0] event_number;
        logic        event_start;
        logic        event_end;
        logic        bad_card;
        logic        overflow;
        logic        last;
    } t_result;

endpackage

[design/rwsd_in_if.sv]
// Input word channel of the deframer.
interface rwsd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink (input valid, input data_word, output ready);
endinterface

[design/rwsd_out_if.sv]
// Result channel of the deframer.
interface rwsd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic [11:0] word_index;
    logic [1:0]  word_kind;
    logic [7:0]  card_id;
    logic [31:0] event_number;
    logic        event_start;
    logic        event_end;
    logic        bad_card;
    logic        overflow;
    logic        last;

    modport source (output valid, output out_word, output word_index, output word_kind,
                    output card_id, output event_number, output event_start,
                    output event_end, output bad_card, output overflow, output last,
                    input ready);
    modport sink (input valid, input out_word, input word_index, input word_kind,
                  input card_id, input event_number, input event_start,
                  input event_end, input bad_card, input overflow, input last,
                  output ready);
endinterface

[design/rwsd_ctrl.sv]
// Controller state machine: input acceptance and head burst sequencing.
module rwsd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  rwsd_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output rwsd_pkg::t_ctl_cmd    o_cmd
);

    rwsd_pkg::t_ctl_state r_state, n_state;
    logic [rwsd_pkg::HEAD_CNT_W-1:0] r_head_cnt, n_head_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rwsd_pkg::S_WORD;
            r_head_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_head_cnt <= n_head_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwsd_pkg::S_WORD: begin
                if (i_in_valid && i_status.out_free && i_status.hdr_full_hit) begin
                    n_state = rwsd_pkg::S_HEAD;
                end
            end
            rwsd_pkg::S_HEAD: begin
                if (i_status.out_free && (r_head_cnt == rwsd_pkg::HEAD_LAST_IDX)) begin
                    n_state = rwsd_pkg::S_WORD;
                end
            end
            default: n_state = rwsd_pkg::S_WORD;
        endcase
    end

    // Outputs and head word counter.
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.head_emit = 1'b0;
        o_cmd.head_idx  = r_head_cnt;
        o_cmd.head_last = (r_head_cnt == rwsd_pkg::HEAD_LAST_IDX);
        n_head_cnt      = r_head_cnt;
        unique case (r_state)
            rwsd_pkg::S_WORD: begin
                o_in_ready   = i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
                if (o_cmd.accept && i_status.hdr_full_hit) begin
                    // The first head word goes out with the header transaction itself.
                    n_head_cnt = rwsd_pkg::HEAD_CNT_W'(1);
                end
            end
            rwsd_pkg::S_HEAD: begin
                o_cmd.head_emit = i_status.out_free;
                if (i_status.out_free) begin
                    n_head_cnt = r_head_cnt + 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[design/rwsd_dp.sv]
// Datapath: word history, frame state, event counter and result register.
module rwsd_dp #(
    parameter int FRAME_DEPTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rwsd_pkg::t_ctl_cmd   i_cmd,
    input  logic [31:0]          i_data_word,
    input  logic [7:0]           i_num_fecs,
    input  logic                 i_out_ready,
    output rwsd_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output rwsd_pkg::t_result    o_result
);

    localparam int IDX_W  = $clog2(FRAME_DEPTH);
    localparam int WIDE_W = (IDX_W > 12) ? IDX_W : 12;
    localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(FRAME_DEPTH - 1);
    localparam logic [IDX_W-1:0] HEAD_END_IDX = IDX_W'(rwsd_pkg::HEAD_WORDS - 1);
    localparam logic [3:0]       HIST_MAX     = 4'(rwsd_pkg::HISTORY_DEPTH);
    localparam logic [3:0]       HIST_FULL    = 4'(rwsd_pkg::HISTORY_DEPTH - 1);

    logic [rwsd_pkg::HIST_STORE-1:0][31:0] r_hist, n_hist;
    logic [rwsd_pkg::HEAD_BUF-1:0][31:0]   r_head, n_head;
    logic [3:0]        r_hist_cnt, n_hist_cnt;
    logic              r_await, n_await;
    logic              r_in_frame, n_in_frame;
    logic [IDX_W-1:0]  r_frame_idx, n_frame_idx;
    logic [7:0]        r_card, n_card;
    logic [31:0]       r_event_cnt, n_event_cnt;
    logic              r_out_valid, n_out_valid;
    rwsd_pkg::t_result r_res, n_res;

    logic             hdr_hit;
    logic             trl_hit;
    logic             hist_full;
    logic             idx_full;
    logic [IDX_W-1:0] idx_next;
    logic [7:0]       head_card;
    logic             st_flag;
    logic             en_flag;

    function automatic logic [11:0] to_word_index(input logic [IDX_W-1:0] idx);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(idx);
        return wide[11:0];
    endfunction

    // A frame of card 1 opens a new event; other cards belong to the open one.
    function automatic logic [31:0] frame_event(input logic [7:0] card,
                                                input logic [31:0] cnt);
        return (card == rwsd_pkg::CARD_FIRST) ? cnt : cnt - 32'd1;
    endfunction

    assign hdr_hit   = r_await && (i_data_word[31:8] == rwsd_pkg::HEADER_TAG);
    assign trl_hit   = (i_data_word == rwsd_pkg::TRAILER_WORD);
    assign hist_full = (r_hist_cnt >= HIST_FULL);
    assign idx_full  = (r_frame_idx == LAST_IDX);
    assign idx_next  = idx_full ? LAST_IDX : r_frame_idx + 1'b1;
    assign head_card = r_hist[rwsd_pkg::CARD_TAP][7:0];
    assign st_flag   = (r_card == rwsd_pkg::CARD_FIRST);
    assign en_flag   = (r_card == i_num_fecs);

    assign o_status.hdr_full_hit = hdr_hit && hist_full;
    assign o_status.out_free     = !r_out_valid || i_out_ready;
    assign o_out_valid           = r_out_valid;
    assign o_result              = r_res;

    always_comb begin
        n_hist      = r_hist;
        n_head      = r_head;
        n_hist_cnt  = r_hist_cnt;
        n_await     = r_await;
        n_in_frame  = r_in_frame;
        n_frame_idx = r_frame_idx;
        n_card      = r_card;
        n_event_cnt = r_event_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res       = r_res;

        if (i_cmd.accept) begin
            n_hist = {r_hist[rwsd_pkg::HIST_STORE-2:0], i_data_word};
            if (r_hist_cnt < HIST_MAX) begin
                n_hist_cnt = r_hist_cnt + 1'b1;
            end
            n_res.event_start = 1'b0;
            n_res.event_end   = 1'b0;
            n_res.bad_card    = 1'b0;
            n_res.overflow    = 1'b0;
            priority if (hdr_hit) begin
                n_await     = 1'b0;
                n_in_frame  = 1'b1;
                n_out_valid = 1'b1;
                if (hist_full) begin
                    // Oldest history word goes out now, the rest from the head buffer.
                    n_card             = head_card;
                    n_head             = r_hist[rwsd_pkg::HEAD_BUF-1:0];
                    n_frame_idx        = HEAD_END_IDX;
                    n_hist_cnt         = 4'd1;
                    n_res.out_word     = r_hist[rwsd_pkg::HIST_STORE-1];
                    n_res.word_index   = 12'd0;
                    n_res.word_kind    = rwsd_pkg::KIND_HEAD;
                    n_res.card_id      = head_card;
                    n_res.event_number = frame_event(head_card, r_event_cnt);
                    n_res.last         = 1'b0;
                end else begin
                    n_res.out_word     = i_data_word;
                    n_res.word_index   = to_word_index(r_frame_idx);
                    n_res.word_kind    = rwsd_pkg::KIND_START_ERR;
                    n_res.card_id      = r_card;
                    n_res.event_number = frame_event(r_card, r_event_cnt);
                    n_res.last         = 1'b1;
                end
            end else if (trl_hit) begin
                n_await            = 1'b1;
                n_in_frame         = 1'b0;
                n_frame_idx        = '0;
                n_out_valid        = 1'b1;
                if (st_flag) begin
                    n_event_cnt = r_event_cnt + 32'd1;
                end
                n_res.out_word     = i_data_word;
                n_res.word_index   = to_word_index(idx_next);
                n_res.word_kind    = rwsd_pkg::KIND_TRAILER;
                n_res.card_id      = r_card;
                n_res.event_number = frame_event(r_card, r_event_cnt);
                n_res.event_start  = st_flag;
                n_res.event_end    = en_flag;
                n_res.bad_card     = !en_flag && (r_card > rwsd_pkg::CARD_MAX_OK);
                n_res.overflow     = idx_full;
                n_res.last         = 1'b1;
            end else if (r_in_frame) begin
                n_frame_idx        = idx_next;
                n_out_valid        = 1'b1;
                n_res.out_word     = idx_full ? 32'd0 : i_data_word;
                n_res.word_index   = to_word_index(idx_next);
                n_res.word_kind    = rwsd_pkg::KIND_PAYLOAD;
                n_res.card_id      = r_card;
                n_res.event_number = frame_event(r_card, r_event_cnt);
                n_res.overflow     = idx_full;
                n_res.last         = 1'b1;
            end
        end

        if (i_cmd.head_emit) begin
            n_head             = {r_head[rwsd_pkg::HEAD_BUF-2:0], 32'd0};
            n_out_valid        = 1'b1;
            n_res.out_word     = r_head[rwsd_pkg::HEAD_BUF-1];
            n_res.word_index   = 12'(i_cmd.head_idx);
            n_res.word_kind    = rwsd_pkg::KIND_HEAD;
            n_res.card_id      = r_card;
            n_res.event_number = frame_event(r_card, r_event_cnt);
            n_res.event_start  = 1'b0;
            n_res.event_end    = 1'b0;
            n_res.bad_card     = 1'b0;
            n_res.overflow     = 1'b0;
            n_res.last         = i_cmd.head_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_cnt  <= '0;
            r_await     <= 1'b1;
            r_in_frame  <= 1'b0;
            r_frame_idx <= HEAD_END_IDX;
            r_card      <= rwsd_pkg::CARD_RESET;
            r_event_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hist_cnt  <= n_hist_cnt;
            r_await     <= n_await;
            r_in_frame  <= n_in_frame;
            r_frame_idx <= n_frame_idx;
            r_card      <= n_card;
            r_event_cnt <= n_event_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hist <= n_hist;
        r_head <= n_head;
        r_res  <= n_res;
    end

endmodule

[design/readout_word_stream_deframer.sv]
// Readout word stream deframer. One raw 32-bit word is taken per cycle while the
// result register is free or being emptied; a word gives at most one result in
// the cycle after it is taken, except a header that opens a frame with a full
// nine-word history, which produces eight head results and holds off input until
// the last of them is emitted. The single result register sets this rate.
// The word kind on the result channel is 0 for a head word, 1 for payload, 2 for
// the trailer and 3 for a header that arrived with too short a history. Register
// num_fecs sits at byte address 0 of the configuration port and resets to 1.
module readout_word_stream_deframer #(
    parameter int FRAME_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rwsd_in_if.sink                           i_word_ch,
    rwsd_out_if.source                        o_res_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rwsd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [7:0]           r_num_fecs;
    logic [7:0]           n_num_fecs;
    rwsd_pkg::t_ctl_cmd   cmd;
    rwsd_pkg::t_dp_status status;
    rwsd_pkg::t_result    res;
    logic                 in_ready;
    logic                 out_valid;

    assign pready = 1'b1;

    always_comb begin
        n_num_fecs = r_num_fecs;
        if (psel && penable && pwrite && (paddr == rwsd_pkg::ADDR_NUM_FECS)) begin
            n_num_fecs = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_fecs <= rwsd_pkg::NUM_FECS_RST;
        end else begin
            r_num_fecs <= n_num_fecs;
        end
    end

    assign prdata = (paddr == rwsd_pkg::ADDR_NUM_FECS) ? {24'd0, r_num_fecs} : 32'd0;

    rwsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_word_ch.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rwsd_dp #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_word (i_word_ch.data_word),
        .i_num_fecs  (r_num_fecs),
        .i_out_ready (o_res_ch.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_result    (res)
    );

    assign i_word_ch.ready       = in_ready;
    assign o_res_ch.valid        = out_valid;
    assign o_res_ch.out_word     = res.out_word;
    assign o_res_ch.word_index   = res.word_index;
    assign o_res_ch.word_kind    = res.word_kind;
    assign o_res_ch.card_id      = res.card_id;
    assign o_res_ch.event_number = res.event_number;
    assign o_res_ch.event_start  = res.event_start;
    assign o_res_ch.event_end    = res.event_end;
    assign o_res_ch.bad_card     = res.bad_card;
    assign o_res_ch.overflow     = res.overflow;
    assign o_res_ch.last         = res.last;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the readout word stream deframer.
`timescale 1ns / 100ps

module testbench;

    localparam int FRAME_DEPTH = 4096;

    // One row of the directed stimulus; typed rows carry their single result.
    typedef struct {
        logic [31:0]       word;
        bit                typed;
        rwsd_pkg::t_result want;
    } t_stim_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [rwsd_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    rwsd_in_if  word_ch ();
    rwsd_out_if res_ch ();

    readout_word_stream_deframer #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word_ch(word_ch),
        .o_res_ch (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Deframer state as the predictor sees it.
    logic [31:0] hist [rwsd_pkg::HISTORY_DEPTH];
    int unsigned hist_fill    = 0;
    bit          want_header  = 1'b1;
    bit          frame_open   = 1'b0;
    int unsigned frame_pos    = 7;
    logic [7:0]  card_now     = rwsd_pkg::CARD_RESET;
    logic [31:0] event_count  = '0;
    logic [7:0]  num_fecs_cfg = rwsd_pkg::NUM_FECS_RST;

    rwsd_pkg::t_result step_out [$];
    rwsd_pkg::t_result due_results [$];

    int mismatches = 0;
    int words_sent = 0;
    int results_checked = 0;
    int head_seen = 0;
    int start_errs_seen = 0;
    int drops_seen = 0;
    int event_ends_seen = 0;
    int bad_cards_seen = 0;
    int settings_run = 0;
    bit in_burst = 1'b0;

    t_stim_row directed_rows [0:19] = '{
        '{32'h0000_0000, 1'b0, '0},
        '{{rwsd_pkg::HEADER_TAG, 8'h00}, 1'b1,
          '{{rwsd_pkg::HEADER_TAG, 8'h00}, 12'd7, rwsd_pkg::KIND_START_ERR,
            rwsd_pkg::CARD_RESET, 32'hffff_ffff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{32'hffff_ffff, 1'b1,
          '{32'hffff_ffff, 12'd8, rwsd_pkg::KIND_PAYLOAD, rwsd_pkg::CARD_RESET,
            32'hffff_ffff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{{rwsd_pkg::HEADER_TAG, 8'hff}, 1'b0, '0},
        '{rwsd_pkg::TRAILER_WORD, 1'b1,
          '{rwsd_pkg::TRAILER_WORD, 12'd10, rwsd_pkg::KIND_TRAILER, rwsd_pkg::CARD_RESET,
            32'hffff_ffff, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{rwsd_pkg::TRAILER_WORD, 1'b0, '0},
        '{32'haaaa_aaaa, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{{24'h000001, rwsd_pkg::CARD_FIRST}, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h7fff_ffff, 1'b0, '0},
        '{32'h0000_ffff, 1'b0, '0},
        '{32'hffff_0000, 1'b0, '0},
        '{{rwsd_pkg::HEADER_TAG + 24'd1, 8'h00}, 1'b0, '0},
        '{{rwsd_pkg::HEADER_TAG, 8'h5a}, 1'b0, '0},
        '{{rwsd_pkg::HEADER_TAG, 8'h01}, 1'b0, '0},
        '{32'hfafa_fafb, 1'b0, '0},
        '{rwsd_pkg::TRAILER_WORD, 1'b1,
          '{rwsd_pkg::TRAILER_WORD, 12'd10, rwsd_pkg::KIND_TRAILER, rwsd_pkg::CARD_FIRST,
            32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{{rwsd_pkg::HEADER_TAG, 8'h00}, 1'b0, '0},
        '{rwsd_pkg::TRAILER_WORD, 1'b0, '0}
    };

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %h, want %h (result %0d)", $realtime, what, got,
                 want, results_checked);
    endtask

    // Card 1 opens a new event; any other card belongs to the event still open.
    function automatic logic [31:0] frame_event_no();
        return (card_now == rwsd_pkg::CARD_FIRST) ? event_count : event_count - 32'd1;
    endfunction

    function automatic rwsd_pkg::t_result make_res(input logic [31:0] w,
                                                   input int unsigned idx,
                                                   input rwsd_pkg::t_word_kind kind);
        rwsd_pkg::t_result r;
        r = '0;
        r.out_word     = w;
        r.word_index   = idx[11:0];
        r.word_kind    = kind;
        r.card_id      = card_now;
        r.event_number = frame_event_no();
        return r;
    endfunction

    function automatic void deframe_word(input logic [31:0] w);
        rwsd_pkg::t_result r;
        bit                ovf;
        step_out.delete();
        for (int k = rwsd_pkg::HISTORY_DEPTH - 1; k > 0; k--) hist[k] = hist[k - 1];
        hist[0] = w;
        if (hist_fill < rwsd_pkg::HISTORY_DEPTH) hist_fill++;

        if (want_header && w[31:8] == rwsd_pkg::HEADER_TAG) begin
            want_header = 1'b0;
            frame_open  = 1'b1;
            if (hist_fill == rwsd_pkg::HISTORY_DEPTH) begin
                card_now = hist[rwsd_pkg::HISTORY_DEPTH - 3][7:0];
                for (int k = 0; k < rwsd_pkg::HEAD_WORDS; k++) begin
                    step_out.push_back(make_res(hist[rwsd_pkg::HISTORY_DEPTH - 1 - k], k,
                                                rwsd_pkg::KIND_HEAD));
                end
                hist_fill = 1;
                frame_pos = 7;
            end else begin
                step_out.push_back(make_res(w, frame_pos, rwsd_pkg::KIND_START_ERR));
            end
        end else if (w == rwsd_pkg::TRAILER_WORD) begin
            want_header = 1'b1;
            frame_open  = 1'b0;
            ovf = (frame_pos + 1 >= FRAME_DEPTH);
            frame_pos = ovf ? FRAME_DEPTH - 1 : frame_pos + 1;
            r = make_res(w, frame_pos, rwsd_pkg::KIND_TRAILER);
            r.event_start = (card_now == rwsd_pkg::CARD_FIRST);
            r.event_end   = (card_now == num_fecs_cfg);
            r.bad_card    = !r.event_end && card_now > rwsd_pkg::CARD_MAX_OK;
            r.overflow    = ovf;
            if (r.event_start) event_count++;
            step_out.push_back(r);
            frame_pos = 0;
        end else if (frame_open) begin
            if (frame_pos + 1 >= FRAME_DEPTH) begin
                // Buffer is full: the word is dropped and only the flag goes out.
                frame_pos = FRAME_DEPTH - 1;
                r = make_res(32'h0, frame_pos, rwsd_pkg::KIND_PAYLOAD);
                r.overflow = 1'b1;
            end else begin
                frame_pos++;
                r = make_res(w, frame_pos, rwsd_pkg::KIND_PAYLOAD);
            end
            step_out.push_back(r);
        end

        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
    endfunction

    task automatic send_word(input logic [31:0] w, input bit typed = 1'b0,
                             input rwsd_pkg::t_result want = '0);
        int gap;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.data_word <= w;
        do @(posedge i_clk); while (!word_ch.ready);
        deframe_word(w);
        if (typed) begin
            due_results.push_back(want);
        end else begin
            foreach (step_out[i]) due_results.push_back(step_out[i]);
        end
        words_sent++;
    endtask

    function automatic logic [7:0] pick_card();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3) return rwsd_pkg::CARD_FIRST;
        if (sel <= 5) return num_fecs_cfg;
        if (sel == 6) return 8'd2;
        if (sel == 7) return rwsd_pkg::CARD_MAX_OK;
        if (sel == 8) return 8'($urandom_range(4, 255));
        return 8'd0;
    endfunction

    // Eight lead-in words (the third carries the card id), header, payload, trailer.
    task automatic send_frame(input int n_payload);
        logic [31:0] w;
        logic [7:0]  card;
        card = pick_card();
        for (int i = 0; i < rwsd_pkg::HEAD_WORDS; i++) begin
            w = $urandom();
            if (i == 2) w[7:0] = card;
            if (w[31:8] == rwsd_pkg::HEADER_TAG) w[31] = ~w[31];
            send_word(w);
        end
        send_word({rwsd_pkg::HEADER_TAG, 8'($urandom_range(0, 255))});
        for (int i = 0; i < n_payload; i++) begin
            w = $urandom();
            if ($urandom_range(0, 9) == 0) w[31:8] = rwsd_pkg::HEADER_TAG;
            if (w == rwsd_pkg::TRAILER_WORD) w[0] = ~w[0];
            send_word(w);
        end
        send_word(rwsd_pkg::TRAILER_WORD);
    endtask

    // Short bursts of stray headers, trailers and near misses that break framing.
    task automatic send_noise();
        int          n;
        int          sel;
        logic [31:0] w;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            w = $urandom();
            if (sel <= 2) w[31:8] = rwsd_pkg::HEADER_TAG;
            else if (sel <= 4) w = rwsd_pkg::TRAILER_WORD;
            else if (sel == 5)
                w[31:8] = rwsd_pkg::HEADER_TAG ^ (24'd1 << $urandom_range(0, 23));
            send_word(w);
        end
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        word_ch.valid <= 1'b0;
        while (due_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (due_results.size() != 0) begin
            flag_mismatch("results never delivered", due_results.size(), 0);
            due_results.delete();
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [rwsd_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [rwsd_pkg::CFG_ADDR_W-1:0] addr,
                            output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: a random stall before each transaction, with stretches of none.
    initial begin
        int stall;
        bit out_burst;
        out_burst    = 1'b0;
        res_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        rwsd_pkg::t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (due_results.size() == 0) begin
                flag_mismatch("result with none expected", res_ch.out_word, 32'h0);
            end else begin
                want = due_results.pop_front();
                if (res_ch.out_word !== want.out_word)
                    flag_mismatch("out_word", res_ch.out_word, want.out_word);
                if (res_ch.word_index !== want.word_index)
                    flag_mismatch("word_index", res_ch.word_index, want.word_index);
                if (res_ch.word_kind !== want.word_kind)
                    flag_mismatch("word_kind", res_ch.word_kind, want.word_kind);
                if (res_ch.card_id !== want.card_id)
                    flag_mismatch("card_id", res_ch.card_id, want.card_id);
                if (res_ch.event_number !== want.event_number)
                    flag_mismatch("event_number", res_ch.event_number, want.event_number);
                if (res_ch.event_start !== want.event_start)
                    flag_mismatch("event_start", res_ch.event_start, want.event_start);
                if (res_ch.event_end !== want.event_end)
                    flag_mismatch("event_end", res_ch.event_end, want.event_end);
                if (res_ch.bad_card !== want.bad_card)
                    flag_mismatch("bad_card", res_ch.bad_card, want.bad_card);
                if (res_ch.overflow !== want.overflow)
                    flag_mismatch("overflow", res_ch.overflow, want.overflow);
                if (res_ch.last !== want.last)
                    flag_mismatch("last", res_ch.last, want.last);
                if (want.word_kind == rwsd_pkg::KIND_HEAD) head_seen++;
                if (want.word_kind == rwsd_pkg::KIND_START_ERR) start_errs_seen++;
                if (want.overflow) drops_seen++;
                if (want.event_end) event_ends_seen++;
                if (want.bad_card) bad_cards_seen++;
            end
            results_checked++;
        end
    end

    initial begin
        logic [7:0]  fecs_plan [5];
        logic [31:0] wdata;
        logic [31:0] rdata;
        int          phase_end;
        fecs_plan = '{8'd3, 8'd255, 8'd2, rwsd_pkg::NUM_FECS_RST, 8'd0};
        fecs_plan[4] = 8'($urandom_range(4, 254));
        word_ch.valid     = 1'b0;
        word_ch.data_word = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        end

        foreach (fecs_plan[p]) begin
            settle();
            wdata = $urandom();
            wdata[7:0] = fecs_plan[p];
            apb_write(rwsd_pkg::ADDR_NUM_FECS, wdata);
            num_fecs_cfg = fecs_plan[p];
            apb_read(rwsd_pkg::ADDR_NUM_FECS, rdata);
            if (rdata[7:0] !== num_fecs_cfg) flag_mismatch("num_fecs readback", rdata, wdata);
            settings_run++;
            phase_end = words_sent + 64;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 3) == 0) send_noise();
                else send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(11, 60)
                                                            : $urandom_range(0, 10));
            end
        end

        settle();
        $display("covered %0d input words and %0d checked results over %0d num_fecs settings",
                 words_sent, results_checked, settings_run);
        $display("head words %0d, start errors %0d, dropped words %0d,",
                 head_seen, start_errs_seen, drops_seen);
        $display("event ends %0d, bad cards %0d", event_ends_seen, bad_cards_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
